/* rtl/crgu2x_pkg.sv */
// ============================================================================
// crgu2x_pkg
// Shared types, constants and weight tables for the 2x Catmull-Rom upsampler.
// ============================================================================
package crgu2x_pkg;

    // Input operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_COARSE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_COARSE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVEL_FLOOR   = 2'd2;
    localparam logic [1:0] REG_LEVEL_SCALE   = 2'd3;

    localparam logic [8:0]  RST_COARSE_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_COARSE_HEIGHT = 9'd256;
    localparam logic [23:0] RST_LEVEL_FLOOR   = 24'd0;
    localparam logic [31:0] RST_LEVEL_SCALE   = 32'd65536;

    // Sixteen coarse taps per query, and the length of the accumulate drain.
    localparam int TAP_COUNT    = 16;
    localparam int DRAIN_CYCLES = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DIFF,
        ST_MUL,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [8:0]         coarse_width;
        logic [8:0]         coarse_height;
        logic signed [23:0] level_floor;
        logic [31:0]        level_scale;
    } cfg_t;

    typedef struct packed {
        logic       mem_write;
        logic       load;
        logic       rd_en;
        logic [3:0] idx;
        logic       calc_diff;
        logic       calc_mul;
        logic       calc_sum;
        logic       out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_oob;
        logic out_free;
    } dp_status_t;

    typedef logic signed [5:0] weight_t;

    // Catmull-Rom weights in sixteenths: half step (-1,9,9,-1), zero step (0,16,0,0).
    function automatic weight_t tap_weight(input logic half, input logic [1:0] tap);
        weight_t w;
        if (half)
        begin
            w = (tap == 2'd1 || tap == 2'd2) ? 6'sd9 : -6'sd1;
        end
        else
        begin
            w = (tap == 2'd1) ? 6'sd16 : 6'sd0;
        end
        return w;
    endfunction

endpackage

/* rtl/catmull_rom_grid_upsample_2x_top.sv */
// ============================================================================
// catmull_rom_grid_upsample_2x_top
// 2x Catmull-Rom upsampler of a coarse height grid with height quantizer.
// ============================================================================
// Input transactions either write one coarse sample (operation 0) or query
// one fine-grid cell (operation 1). Each query gives one output transaction
// carrying quantized_height; writes give none. A transaction moves when
// valid is high and stall is low at a rising edge of clk.
// A write is absorbed in its acceptance cycle; the next item can follow in
// the next cycle. A query reads sixteen coarse taps through the single port
// of the grid RAM, one per cycle, then drains the accumulators and runs the
// quantizer difference, multiply and sum steps before the next item is
// taken. A query outside the fine grid skips the tap reads and returns 0.
// While the output register holds an unaccepted result, a new item is still
// taken and processed; its result waits until the output stall drops.
// Reset (rst_n low) empties the pipeline and restores the configuration
// registers; the grid RAM is not cleared and must be written before use.
// The user writes configuration over the APB-style port only while idle (unchecked).
// ============================================================================
module catmull_rom_grid_upsample_2x_top #(
    parameter int MAX_COARSE_COLUMNS = 256,
    parameter int MAX_COARSE_ROWS    = 256,
    parameter int HEIGHT_BITS        = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic [8:0]         grid_row,
    input  logic [8:0]         grid_column,
    input  logic signed [23:0] sample_height,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [15:0]        quantized_height
);
    import crgu2x_pkg::*;

    logic [8:0]         width_reg, height_reg;
    logic signed [23:0] floor_reg;
    logic [31:0]        scale_reg;
    logic               cfg_write;
    logic [1:0]         reg_index;
    cfg_t               cfg;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_COARSE_WIDTH;
            height_reg <= RST_COARSE_HEIGHT;
            floor_reg  <= RST_LEVEL_FLOOR;
            scale_reg  <= RST_LEVEL_SCALE;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_COARSE_WIDTH:  width_reg  <= pwdata[8:0];
                REG_COARSE_HEIGHT: height_reg <= pwdata[8:0];
                REG_LEVEL_FLOOR:   floor_reg  <= pwdata[23:0];
                REG_LEVEL_SCALE:   scale_reg  <= pwdata;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_COARSE_WIDTH:  prdata = {23'b0, width_reg};
            REG_COARSE_HEIGHT: prdata = {23'b0, height_reg};
            REG_LEVEL_FLOOR:   prdata = {8'b0, floor_reg};
            REG_LEVEL_SCALE:   prdata = scale_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.coarse_width  = width_reg;
    assign cfg.coarse_height = height_reg;
    assign cfg.level_floor   = floor_reg;
    assign cfg.level_scale   = scale_reg;

    crgu2x_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    crgu2x_dp #(
        .MAX_COARSE_COLUMNS (MAX_COARSE_COLUMNS),
        .MAX_COARSE_ROWS    (MAX_COARSE_ROWS),
        .HEIGHT_BITS        (HEIGHT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .grid_row         (grid_row),
        .grid_column      (grid_column),
        .sample_height    (sample_height),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .quantized_height (quantized_height)
    );

endmodule

/* rtl/crgu2x_ram.sv */
// ============================================================================
// crgu2x_ram
// Generic single-port RAM with registered read data.
// ============================================================================
module crgu2x_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/crgu2x_ctrl.sv */
// ============================================================================
// crgu2x_ctrl
// Sequencer: accepts transactions, steps the sixteen tap reads, the
// accumulate drain and the quantizer stages, and hands off the result.
// ============================================================================
module crgu2x_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   operation,
    output logic                   in_stall,
    input  crgu2x_pkg::dp_status_t status,
    output crgu2x_pkg::ctrl_cmd_t  cmd
);
    import crgu2x_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (operation == OP_WRITE)
                    begin
                        cmd.mem_write = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        cnt_next   = '0;
                        state_next = status.in_oob ? ST_DONE : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
                cmd.idx   = cnt_reg;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'(TAP_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'(DRAIN_CYCLES - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_read_to_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ && cnt_reg == 4'(TAP_COUNT - 1)) |=> state_reg == ST_DRAIN)
        else $error("tap sequence did not end after the last read");
    a_oob_shortcut: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && operation == OP_QUERY && status.in_oob)
        |=> state_reg == ST_DONE)
        else $error("out-of-grid query did not go straight to the result");
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !status.out_free) |=> state_reg == ST_DONE)
        else $error("result dropped while the output register was busy");
`endif

endmodule

/* rtl/crgu2x_dp.sv */
// ============================================================================
// crgu2x_dp
// Datapath: coarse grid RAM, tap address generation with column wrap and
// row clamp, row and column accumulators, quantizer and output register.
// ============================================================================
module crgu2x_dp #(
    parameter int MAX_COARSE_COLUMNS = 256,
    parameter int MAX_COARSE_ROWS    = 256,
    parameter int HEIGHT_BITS        = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  crgu2x_pkg::cfg_t       cfg,
    input  crgu2x_pkg::ctrl_cmd_t  cmd,
    output crgu2x_pkg::dp_status_t status,
    input  logic [8:0]             grid_row,
    input  logic [8:0]             grid_column,
    input  logic signed [23:0]     sample_height,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [15:0]            quantized_height
);
    import crgu2x_pkg::*;

    localparam int COL_AW  = $clog2(MAX_COARSE_COLUMNS);
    localparam int ROW_AW  = $clog2(MAX_COARSE_ROWS);
    localparam int ADDR_W  = ROW_AW + COL_AW;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int TERM_W  = HEIGHT_BITS + 5;
    localparam int SUM_W   = HEIGHT_BITS + 10;
    localparam int D_W     = ((SUM_W > 32) ? SUM_W : 32) + 1;
    localparam int UD_W    = D_W - 1;
    localparam int PROD_W  = UD_W + 16;
    localparam int M_W     = PROD_W + 1;
    localparam int QV_W    = M_W - 15;

    // Effective grid size: zero reads as one, large values clip to the store.
    logic [9:0] w_eff, h_eff;

    always_comb
    begin
        if (cfg.coarse_width == 9'd0)
        begin
            w_eff = 10'd1;
        end
        else if (32'(cfg.coarse_width) > MAX_COARSE_COLUMNS)
        begin
            w_eff = 10'(MAX_COARSE_COLUMNS);
        end
        else
        begin
            w_eff = {1'b0, cfg.coarse_width};
        end
        if (cfg.coarse_height == 9'd0)
        begin
            h_eff = 10'd1;
        end
        else if (32'(cfg.coarse_height) > MAX_COARSE_ROWS)
        begin
            h_eff = 10'(MAX_COARSE_ROWS);
        end
        else
        begin
            h_eff = {1'b0, cfg.coarse_height};
        end
    end

    logic [10:0] fine_w, fine_h;
    assign fine_w = {w_eff, 1'b0};
    assign fine_h = {h_eff, 1'b0} - 11'd1;

    assign status.in_oob = ({2'b0, grid_column} >= fine_w) || ({2'b0, grid_row} >= fine_h);

    // Query registers.
    logic [7:0] c0_reg, r0_reg;
    logic       col_odd_reg, row_odd_reg, oob_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            c0_reg      <= grid_column[8:1];
            r0_reg      <= grid_row[8:1];
            col_odd_reg <= grid_column[0];
            row_odd_reg <= grid_row[0];
            oob_reg     <= status.in_oob;
        end
    end

    // Tap address: column c0-1+j wraps, row r0-1+k clamps.
    logic [10:0] c_plus, c_minus, c_fin;
    logic [10:0] r_plus, r_minus, r_fin;
    logic [10:0] w_ext, h_top;

    assign w_ext = {1'b0, w_eff};
    assign h_top = {1'b0, h_eff} - 11'd1;

    always_comb
    begin
        c_plus  = {3'b0, c0_reg} + {9'b0, cmd.idx[1:0]};
        c_minus = c_plus - 11'd1;
        if (w_eff == 10'd1)
        begin
            c_fin = '0;
        end
        else if (c_plus == 11'd0)
        begin
            c_fin = w_ext - 11'd1;
        end
        else if (c_minus >= w_ext)
        begin
            c_fin = c_minus - w_ext;
        end
        else
        begin
            c_fin = c_minus;
        end
        r_plus  = {3'b0, r0_reg} + {9'b0, cmd.idx[3:2]};
        r_minus = r_plus - 11'd1;
        if (r_plus == 11'd0)
        begin
            r_fin = '0;
        end
        else if (r_minus > h_top)
        begin
            r_fin = h_top;
        end
        else
        begin
            r_fin = r_minus;
        end
    end

    // Coarse store.
    logic                   wr_ok, mem_en;
    logic [ADDR_W-1:0]      mem_addr;
    logic signed [31:0]     sample_ext;
    logic [HEIGHT_BITS-1:0] rd_data;

    assign wr_ok      = (32'(grid_row) < MAX_COARSE_ROWS) && (32'(grid_column) < MAX_COARSE_COLUMNS);
    assign mem_en     = cmd.rd_en || (cmd.mem_write && wr_ok);
    assign sample_ext = 32'(sample_height);
    assign mem_addr   = cmd.mem_write ? {ROW_AW'(grid_row), COL_AW'(grid_column)}
                                      : {ROW_AW'(r_fin), COL_AW'(c_fin)};

    crgu2x_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .en    (mem_en),
        .we    (cmd.mem_write),
        .addr  (mem_addr),
        .wdata (sample_ext[HEIGHT_BITS-1:0]),
        .rdata (rd_data)
    );

    // Row pass then column pass, one tap per cycle.
    logic              valid_d_reg, rv_done_reg;
    logic [3:0]        idx_d_reg;
    logic [1:0]        rv_k_reg;
    logic signed [TERM_W-1:0] s_ext, wc_ext, term, rv_reg, rv_next;
    logic signed [SUM_W-1:0]  rv_wide, wr_ext, h_reg, h_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_d_reg <= 1'b0;
            rv_done_reg <= 1'b0;
        end
        else
        begin
            valid_d_reg <= cmd.rd_en;
            rv_done_reg <= valid_d_reg && (idx_d_reg[1:0] == 2'd3);
        end
    end

    always_comb
    begin
        s_ext   = TERM_W'($signed(rd_data));
        wc_ext  = TERM_W'(tap_weight(col_odd_reg, idx_d_reg[1:0]));
        term    = s_ext * wc_ext;
        rv_next = ((idx_d_reg[1:0] == 2'd0) ? '0 : rv_reg) + term;
        rv_wide = SUM_W'(rv_reg);
        wr_ext  = SUM_W'(tap_weight(row_odd_reg, rv_k_reg));
        h_next  = ((rv_k_reg == 2'd0) ? '0 : h_reg) + rv_wide * wr_ext;
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg <= cmd.idx;
        if (valid_d_reg)
        begin
            rv_reg   <= rv_next;
            rv_k_reg <= idx_d_reg[3:2];
        end
        if (rv_done_reg)
        begin
            h_reg <= h_next;
        end
    end

    // Quantizer: difference, split multiply, round and saturate.
    logic                   even_even;
    logic signed [D_W-1:0]  h_d, floor_d, d_next, d_reg;
    logic [UD_W-1:0]        ud;
    logic [PROD_W-1:0]      a_reg, b_reg;
    logic [M_W-1:0]         m_sum;
    logic [M_W:0]           m_round;
    logic [QV_W-1:0]        qv;
    logic [15:0]            q_reg;

    always_comb
    begin
        even_even = !col_odd_reg && !row_odd_reg;
        h_d       = (!even_even && h_reg < 0) ? '0 : D_W'(h_reg);
        floor_d   = D_W'($signed({cfg.level_floor, 8'b0}));
        d_next    = h_d - floor_d;
        ud        = (d_reg > 0) ? d_reg[UD_W-1:0] : '0;
        m_sum     = M_W'(b_reg) + M_W'(a_reg >> 16);
        m_round   = (M_W + 1)'(m_sum) + (M_W + 1)'(32768);
        qv        = m_round[M_W:16];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc_diff)
        begin
            d_reg <= d_next;
        end
        if (cmd.calc_mul)
        begin
            a_reg <= PROD_W'(ud) * PROD_W'(cfg.level_scale[15:0]);
            b_reg <= PROD_W'(ud) * PROD_W'(cfg.level_scale[31:16]);
        end
        if (cmd.calc_sum)
        begin
            q_reg <= (|qv[QV_W-1:16]) ? 16'hFFFF : qv[15:0];
        end
    end

    // Output register.
    logic        out_valid_reg;
    logic [15:0] qh_reg;

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            qh_reg <= oob_reg ? 16'd0 : q_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign quantized_height = qh_reg;

`ifndef SYNTHESIS
    a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.mem_write && cmd.rd_en))
        else $error("sample write and tap read on the RAM in one cycle");
    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calc_diff |-> (!valid_d_reg && !rv_done_reg))
        else $error("quantizer started before the accumulators drained");
`endif

endmodule
